/* rtl/core/rpf_pkg.sv */
// Shared widths, latencies, types and register indexes of the repulsive pair force block.
package rpf_pkg;

  localparam int DISP_W = 24;
  localparam int SIZE_W = 16;
  localparam int STR_W  = 24;
  localparam int F_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam int SQ_W   = 2 * DISP_W;      // one squared component
  localparam int R2_W   = 48;              // sum of three squares
  localparam int SS_W   = 2 * SIZE_W;
  localparam int C2_W   = 34;              // 3*s^2
  localparam int A_W    = DISP_W + STR_W;  // |d|*eps
  localparam int X_W    = 44;              // x in Q12.32
  localparam int V_W    = 61;              // chain value below the cap
  localparam int SUM_W  = 74;
  localparam int D_W    = 69;              // g * (128 or 192)
  localparam int Q_W    = 32;

  localparam int XDIV_LAT  = X_W;
  localparam int FRC_STEPS = 8;
  localparam int SUB_STEP  = 3;
  localparam int FRC_LAT   = 2 * FRC_STEPS + 2 + Q_W;
  localparam int PIPE_LAT  = 2 + XDIV_LAT + FRC_LAT + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd1;
  localparam logic [STR_W-1:0]     STRENGTH_RST = 24'd65536;

  typedef struct packed {
    logic [V_W-1:0]  v;
    logic            sat;
    logic [X_W-1:0]  x;
    logic [A_W-1:0]  a;
    logic [C2_W-1:0] c2;
  } chain_t;

  typedef struct packed {
    logic [40:0] hh;
    logic [60:0] hl;
    logic [43:0] lh;
    logic [31:0] ll;
    logic        act;
    chain_t      base;
  } pp_t;

  typedef struct packed {
    logic [C2_W-1:0] rem;
    logic [Q_W-1:0]  lo;
    logic [Q_W-1:0]  q;
    logic [C2_W-1:0] c2;
    logic            sat;
  } div_t;

  typedef struct packed {
    logic [2:0][A_W-1:0] a;
    logic [2:0]          neg;
    logic [C2_W-1:0]     c2;
    logic                beyond;
    logic                zero;
    logic                xbig;
  } sb1_t;

  typedef struct packed {
    logic [2:0] neg;
    logic [2:0] azero;
    logic       beyond;
    logic       zero;
  } sb2_t;

endpackage

/* rtl/core/rpf_xdiv.sv */
// Pipelined restoring divider forming x = c2/r2 in Q12.32, one quotient bit per stage.
module rpf_xdiv import rpf_pkg::*; (
  input  logic            clk,
  input  logic            adv,
  input  logic [R2_W-1:0] r2,
  input  logic [C2_W-1:0] c2,
  output logic [X_W-1:0]  x
);

  logic [R2_W-1:0] rem_r [0:XDIV_LAT-1];
  logic [R2_W-1:0] dvs_r [0:XDIV_LAT-1];
  logic [X_W-1:0]  q_r   [0:XDIV_LAT-1];

  for (genvar i = 0; i < XDIV_LAT; i++) begin : g_stg
    logic [R2_W-1:0] prem;
    logic [R2_W-1:0] pdvs;
    logic [X_W-1:0]  pq;
    logic [R2_W:0]   t;
    logic            ge;

    if (i == 0) begin : g_first
      assign prem = R2_W'(c2);
      assign pdvs = r2;
      assign pq   = '0;
    end else begin : g_next
      assign prem = rem_r[i-1];
      assign pdvs = dvs_r[i-1];
      assign pq   = q_r[i-1];
    end

    assign t  = {prem, 1'b0};
    assign ge = t >= {1'b0, pdvs};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= ge ? R2_W'(t - {1'b0, pdvs}) : t[R2_W-1:0];
        dvs_r[i] <= pdvs;
        q_r[i]   <= {pq[X_W-2:0], ge};
      end
    end
  end

  assign x = q_r[XDIV_LAT-1];

endmodule

/* rtl/core/rpf_force.sv */
// One force component: x-product chain with sticky saturation, scaled, divided by c2.
module rpf_force import rpf_pkg::*; (
  input  logic           clk,
  input  logic           adv,
  input  logic           mode,
  input  chain_t         c_in,
  output logic [Q_W-1:0] q,
  output logic           sat
);

  pp_t    pp_r [0:FRC_STEPS-1];
  chain_t ch_r [1:FRC_STEPS];

  for (genvar i = 0; i < FRC_STEPS; i++) begin : g_step
    chain_t          cur;
    chain_t          base;
    chain_t          ch_nxt;
    logic [X_W-1:0]  y;
    logic            act;
    logic [63:0]     pll;
    logic [V_W-4:0]  b3;
    logic [SUM_W-1:0] s;

    if (i == 0) begin : g_first
      assign cur = c_in;
    end else begin : g_next
      assign cur = ch_r[i];
    end

    always_comb begin
      y = cur.x;
      if (i == 0 && !mode) begin
        y = {1'b0, cur.x[X_W-1:1]} - X_W'(64'h1_0000_0000);
      end
      if (i == SUB_STEP) begin
        act = 1'b0;
      end else if (i == 1 || i == 2) begin
        act = mode;
      end else begin
        act = 1'b1;
      end
      b3   = cur.v[V_W-1:3];
      base = cur;
      if (i == SUB_STEP && mode) begin
        base.v = (b3 > (V_W-3)'(cur.a)) ? V_W'(b3 - (V_W-3)'(cur.a)) : '0;
      end
      pll = 64'(cur.v[31:0]) * 64'(y[31:0]);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pp_r[i].hh   <= 41'(cur.v[60:32]) * 41'(y[43:32]);
        pp_r[i].hl   <= 61'(cur.v[60:32]) * 61'(y[31:0]);
        pp_r[i].lh   <= 44'(cur.v[31:0]) * 44'(y[43:32]);
        pp_r[i].ll   <= pll[63:32];
        pp_r[i].act  <= act;
        pp_r[i].base <= base;
      end
    end

    assign s = {1'b0, pp_r[i].hh, 32'b0} + SUM_W'(pp_r[i].hl) + SUM_W'(pp_r[i].lh)
             + SUM_W'(pp_r[i].ll);

    always_comb begin
      ch_nxt = pp_r[i].base;
      if (pp_r[i].act) begin
        ch_nxt.v   = s[V_W-1:0];
        ch_nxt.sat = pp_r[i].base.sat | (|s[SUM_W-1:V_W]);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ch_r[i+1] <= ch_nxt;
      end
    end
  end

  logic [D_W-1:0]  d_r;
  logic [C2_W-1:0] dc2_r;
  logic            dsat_r;
  logic [D_W-1:0]  gw;
  div_t            iv_r;
  div_t            dv_r [0:Q_W-1];

  assign gw = D_W'(ch_r[FRC_STEPS].v);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r    <= mode ? (gw << 7) + (gw << 6) : (gw << 7);
      dc2_r  <= ch_r[FRC_STEPS].c2;
      dsat_r <= ch_r[FRC_STEPS].sat;
      iv_r.rem <= d_r[C2_W+Q_W-1:Q_W];
      iv_r.lo  <= d_r[Q_W-1:0];
      iv_r.q   <= '0;
      iv_r.c2  <= dc2_r;
      iv_r.sat <= dsat_r | (d_r[D_W-1:Q_W] >= (D_W-Q_W)'(dc2_r));
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    div_t          pv;
    logic [C2_W:0] t;
    logic          ge;

    if (j == 0) begin : g_first
      assign pv = iv_r;
    end else begin : g_next
      assign pv = dv_r[j-1];
    end

    assign t  = {pv.rem, pv.lo[Q_W-1]};
    assign ge = t >= {1'b0, pv.c2};

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j].rem <= ge ? C2_W'(t - {1'b0, pv.c2}) : t[C2_W-1:0];
        dv_r[j].lo  <= {pv.lo[Q_W-2:0], 1'b0};
        dv_r[j].q   <= {pv.q[Q_W-2:0], ge};
        dv_r[j].c2  <= pv.c2;
        dv_r[j].sat <= pv.sat;
      end
    end
  end

  assign q   = dv_r[Q_W-1].q;
  assign sat = dv_r[Q_W-1].sat;

endmodule

/* rtl/core/repulsive_pair_force_top.sv */
// Top level of the repulsive pair force pipeline.
// Throughput one item per cycle unless a stalled result holds the pipeline.
// The x divider (44 stages) and per-component chain and divider (50 stages) set the depth.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits, mode to 8-6 and strength to 1.0.
module repulsive_pair_force_top import rpf_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_idx,
  input  logic [STR_W-1:0]            cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [DISP_W-1:0]    in_dx,
  input  logic signed [DISP_W-1:0]    in_dy,
  input  logic signed [DISP_W-1:0]    in_dz,
  input  logic [SIZE_W-1:0]           in_bead_size,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [F_W-1:0]       out_fx,
  output logic signed [F_W-1:0]       out_fy,
  output logic signed [F_W-1:0]       out_fz,
  output logic                        out_in_range,
  output logic                        out_clipped
);

  logic             mode_r;
  logic [STR_W-1:0] strength_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      strength_r <= STRENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE:     mode_r     <= cfg_wdata[0];
        CFG_STRENGTH: strength_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [PIPE_LAT-1:0] vld_r;
  logic                adv;

  assign adv       = !vld_r[PIPE_LAT-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // stage 1: magnitudes and squares
  logic [2:0][DISP_W-1:0] dv;
  logic [2:0][DISP_W-1:0] mag;
  logic [2:0][DISP_W-1:0] mag_r;
  logic [2:0][SQ_W-1:0]   sq_r;
  logic [2:0]             neg_r;
  logic [SS_W-1:0]        ss_r;

  assign dv = {in_dz, in_dy, in_dx};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = dv[k][DISP_W-1] ? (~dv[k] + 1'b1) : dv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= mag[k];
        sq_r[k]  <= SQ_W'(mag[k]) * SQ_W'(mag[k]);
        neg_r[k] <= dv[k][DISP_W-1];
      end
      ss_r <= SS_W'(in_bead_size) * SS_W'(in_bead_size);
    end
  end

  // stage 2: r2, c2, cutoff flags, |d|*eps
  logic [R2_W-1:0] r2;
  logic [C2_W-1:0] c2;
  logic [R2_W-1:0] r2_r;
  sb1_t            sb;
  sb1_t            s2_r;

  always_comb begin
    r2 = R2_W'(sq_r[0]) + R2_W'(sq_r[1]) + R2_W'(sq_r[2]);
    c2 = (C2_W'(ss_r) << 1) + C2_W'(ss_r);
    for (int k = 0; k < 3; k++) begin
      sb.a[k] = A_W'(mag_r[k]) * A_W'(strength_r);
    end
    sb.neg    = neg_r;
    sb.c2     = c2;
    sb.beyond = {r2, 1'b0} > (R2_W+1)'({c2, 12'b0});
    sb.zero   = r2 == '0;
    sb.xbig   = R2_W'(c2) >= r2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= sb;
      r2_r <= r2;
    end
  end

  // x = c2/r2
  logic [X_W-1:0] x;
  sb1_t           sb1_r [0:XDIV_LAT-1];

  rpf_xdiv u_xdiv (
    .clk (clk),
    .adv (adv),
    .r2  (r2_r),
    .c2  (s2_r.c2),
    .x   (x)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1_r[0] <= s2_r;
      for (int i = 1; i < XDIV_LAT; i++) begin
        sb1_r[i] <= sb1_r[i-1];
      end
    end
  end

  // per-component force chain
  sb1_t                xs;
  sb2_t                sb2_in;
  sb2_t                sb2_r [0:FRC_LAT-1];
  logic [2:0][Q_W-1:0] fq;
  logic [2:0]          fsat;

  assign xs = sb1_r[XDIV_LAT-1];

  for (genvar k = 0; k < 3; k++) begin : g_comp
    chain_t cin;

    assign cin = '{v: V_W'(xs.a[k]), sat: xs.xbig, x: x, a: xs.a[k], c2: xs.c2};

    rpf_force u_force (
      .clk  (clk),
      .adv  (adv),
      .mode (mode_r),
      .c_in (cin),
      .q    (fq[k]),
      .sat  (fsat[k])
    );

    assign sb2_in.azero[k] = xs.a[k] == '0;
  end

  assign sb2_in.neg    = xs.neg;
  assign sb2_in.beyond = xs.beyond;
  assign sb2_in.zero   = xs.zero;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb2_r[0] <= sb2_in;
      for (int i = 1; i < FRC_LAT; i++) begin
        sb2_r[i] <= sb2_r[i-1];
      end
    end
  end

  // output stage: clamp, sign, flags
  sb2_t                fs;
  logic [2:0][F_W-1:0] fo;
  logic [2:0]          clip;
  logic [2:0]          nz;
  logic [F_W-1:0]      lim;
  logic [F_W-1:0]      m;
  logic                rng;
  logic                clp;

  assign fs = sb2_r[FRC_LAT-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lim     = fs.neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      clip[k] = !fs.azero[k] && (fsat[k] || fq[k] > lim);
      m       = fs.azero[k] ? '0 : (clip[k] ? lim : fq[k]);
      nz[k]   = m != '0;
      fo[k]   = fs.neg[k] ? (~m + 1'b1) : m;
    end
    rng = |nz;
    clp = |clip;
    if (fs.beyond) begin
      fo  = '0;
      rng = 1'b0;
      clp = 1'b0;
    end else if (fs.zero) begin
      fo  = '0;
      rng = 1'b0;
      clp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fx       <= fo[0];
      out_fy       <= fo[1];
      out_fz       <= fo[2];
      out_in_range <= rng;
      out_clipped  <= clp;
    end
  end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for repulsive_pair_force_top: random traffic, stalls, force prediction.
`timescale 1ns / 1ps

module tb_top;
  import rpf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint unsigned CHAIN_CAP = 64'h2000_0000_0000_0000;
  localparam longint unsigned X_LIMIT   = 4096;

  typedef struct {
    logic [DISP_W-1:0] dx, dy, dz;
    logic [SIZE_W-1:0] size;
  } pair_t;

  typedef struct {
    logic [F_W-1:0] fx, fy, fz;
    logic           in_range, clipped;
  } force_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [STR_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [DISP_W-1:0] in_dx = '0, in_dy = '0, in_dz = '0;
  logic [SIZE_W-1:0] in_bead_size = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [F_W-1:0] out_fx, out_fy, out_fz;
  logic out_in_range, out_clipped;

  pair_t  pending[$];
  force_t expected_forces[$];
  bit     mode_12_6 = 0;
  logic [STR_W-1:0] eps = STRENGTH_RST;
  bit     hold = 1, quiet = 0, failed = 0;
  int     send_gap = 0, recv_gap = 0;

  repulsive_pair_force_top DUT (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned times_x(longint unsigned a, longint unsigned x,
                                              inout bit sat);
    longint unsigned hh, sum;
    if (sat) return CHAIN_CAP;
    hh = (a >> 32) * (x >> 32);
    if (hh > (CHAIN_CAP >> 32)) begin
      sat = 1;
      return CHAIN_CAP;
    end
    sum = (hh << 32) + (a >> 32) * (x & 32'hFFFFFFFF) + (a & 32'hFFFFFFFF) * (x >> 32)
        + (((a & 32'hFFFFFFFF) * (x & 32'hFFFFFFFF)) >> 32);
    if (sum >= CHAIN_CAP) begin
      sat = 1;
      return CHAIN_CAP;
    end
    return sum;
  endfunction

  function automatic force_t pair_force(pair_t p);
    force_t f;
    logic [DISP_W-1:0] d[3];
    longint unsigned mag[3], r2, c2, c2w, qi, rem, f1, f2, x, mult, a, g, m, q, lim;
    bit neg[3], xbig, any, clip, sat;
    d = '{p.dx, p.dy, p.dz};
    f = '{default: 0};
    r2 = 0; x = 0; xbig = 0; any = 0; clip = 0;
    for (int k = 0; k < 3; k++) begin
      neg[k] = d[k][DISP_W-1];
      mag[k] = neg[k] ? (64'h100_0000 - d[k]) : d[k];
      r2 += mag[k] * mag[k];
    end
    c2 = 3 * longint'(p.size) * longint'(p.size);
    c2w = c2 << 12;
    if (2 * r2 > c2w) return f;
    if (r2 == 0) begin
      f.clipped = 1;
      return f;
    end
    qi = c2w / r2;
    if (qi >= X_LIMIT) xbig = 1;
    else begin
      rem = c2w - qi * r2;
      f1 = (rem << 16) / r2;
      rem = (rem << 16) % r2;
      f2 = (rem << 16) / r2;
      x = (qi << 32) | (f1 << 16) | f2;
    end
    mult = mode_12_6 ? 192 : 128;
    for (int k = 0; k < 3; k++) begin
      a = mag[k] * longint'(eps);
      g = 0; m = 0; sat = xbig;
      if (a == 0) continue;
      if (!sat) begin
        if (mode_12_6) begin
          g = times_x(a, x, sat);
          g = times_x(g, x, sat);
          g = times_x(g, x, sat);
          g = ((g >> 3) > a) ? (g >> 3) - a : 0;
        end else begin
          g = times_x(a, (x >> 1) - (64'd1 << 32), sat);
        end
        for (int j = 0; j < 4; j++) g = times_x(g, x, sat);
      end
      if (!sat) begin
        q = g / c2;
        if (q >= (64'd1 << 25)) sat = 1;
        else m = q * mult + ((g % c2) * mult) / c2;
      end
      lim = neg[k] ? (64'd1 << 31) : ((64'd1 << 31) - 1);
      if (sat || m > lim) begin
        m = lim;
        clip = 1;
      end
      if (m != 0) any = 1;
      m = neg[k] ? ((64'd1 << 32) - m) : m;
      if (k == 0) f.fx = m[31:0];
      else if (k == 1) f.fy = m[31:0];
      else f.fz = m[31:0];
    end
    f.in_range = any;
    f.clipped = clip;
    return f;
  endfunction

  // sender
  always @(posedge clk) begin
    pair_t p;
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_forces.push_back(pair_force(pair_t'{in_dx, in_dy, in_dz, in_bead_size}));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 0;
        end else if (!hold && pending.size() > 0) begin
          p = pending.pop_front();
          in_dx <= p.dx;
          in_dy <= p.dy;
          in_dz <= p.dz;
          in_bead_size <= p.size;
          in_valid <= 1;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    force_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_forces.size() == 0) begin
          $error("unexpected result");
          failed = 1;
        end else begin
          e = expected_forces.pop_front();
          if (out_fx !== e.fx) begin
            $error("fx expected %h got %h", e.fx, out_fx); failed = 1;
          end
          if (out_fy !== e.fy) begin
            $error("fy expected %h got %h", e.fy, out_fy); failed = 1;
          end
          if (out_fz !== e.fz) begin
            $error("fz expected %h got %h", e.fz, out_fz); failed = 1;
          end
          if (out_in_range !== e.in_range) begin
            $error("in_range expected %b got %b", e.in_range, out_in_range); failed = 1;
          end
          if (out_clipped !== e.clipped) begin
            $error("clipped expected %b got %b", e.clipped, out_clipped); failed = 1;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 15);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic add_pair(int dx, int dy, int dz, int size);
    pending.push_back(pair_t'{dx[DISP_W-1:0], dy[DISP_W-1:0], dz[DISP_W-1:0],
                              size[SIZE_W-1:0]});
  endtask

  function automatic int inside_comp(int size);
    int m;
    m = $urandom_range(0, size * 45);
    if ($urandom_range(0, 3) == 0) m = m >> $urandom_range(1, 12);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic add_random(int n);
    int s;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1:
          add_pair($urandom, $urandom, $urandom, $urandom);
        2: begin
          s = $urandom_range(0, 65535);
          add_pair($urandom_range(0, 3) - 2, $urandom_range(0, 3) - 2, $urandom_range(0, 3) - 2, s);
        end
        default: begin
          s = $urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 4000);
          add_pair(inside_comp(s), inside_comp(s), inside_comp(s), s);
        end
      endcase
    end
  endtask

  task automatic drain();
    hold = 0;
    while (pending.size() > 0 || in_valid || expected_forces.size() > 0) @(posedge clk);
    hold = 1;
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STR_W-1:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == CFG_MODE) mode_12_6 = val[0];
    else if (idx == CFG_STRENGTH) eps = val;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    add_pair(0, 0, 0, 16384);
    add_pair(0, 0, 0, 0);
    add_pair(1, 0, 0, 0);
    add_pair(-8388608, -8388608, -8388608, 65535);
    add_pair(8388607, 8388607, 8388607, 65535);
    add_pair(8388607, 0, 0, 16384);
    add_pair(1, 0, 0, 65535);
    add_pair(-1, 1, -1, 65535);
    add_pair(1 << 20, 0, 0, 1 << 14);
    add_pair(-(1 << 20), 0, 0, 1 << 14);
    add_pair(880000, 0, 0, 1 << 14);
    add_pair(0, 700000, -300000, 1 << 14);
    add_pair(0, 0, 1284000, 1 << 14);
    add_pair(300000, -400000, 500000, 30000);
    add_pair(0, -5000, 0, 2000);
    add_pair(4000000, 4000000, 0, 65535);
    drain();
    write_reg(CFG_MODE, STR_W'(1));
    add_pair(880000, 0, 0, 1 << 14);
    add_pair(-1, 1, -1, 65535);
    add_pair(0, -5000, 0, 2000);
    add_pair(-8388608, 8388607, 0, 65535);
    add_random(110);
    drain();
    write_reg(CFG_STRENGTH, STR_W'(0));
    add_random(110);
    drain();
    write_reg(CFG_MODE, STR_W'(0));
    write_reg(CFG_STRENGTH, 24'hFFFFFF);
    add_random(110);
    drain();
    write_reg(CFG_MODE, STR_W'(1));
    write_reg(CFG_SPARE, 24'h000000);
    add_random(110);
    drain();
    write_reg(CFG_STRENGTH, STR_W'($urandom_range(1, 24'hFFFFFF)));
    write_reg(CFG_MODE, STR_W'(0));
    write_reg(CFG_SPARE, 24'hFFFFFF);
    add_random(110);
    drain();
    quiet = 1;
    write_reg(CFG_MODE, STR_W'($urandom_range(0, 1)));
    write_reg(CFG_STRENGTH, STR_W'($urandom_range(0, 24'h3FFFF)));
    add_random(120);
    drain();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (!failed && expected_forces.size() == 0 && !out_valid) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
